// ===== sv/gmsc_pkg.sv =====
package gmsc_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_CHECK = 2'd1,
    OP_STAMP = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    REG_MASK_COLS        = 3'd0,
    REG_MASK_ROWS        = 3'd1,
    REG_CENTER_COL       = 3'd2,
    REG_CENTER_ROW       = 3'd3,
    REG_CHECK_MASK_VALUE = 3'd4,
    REG_CHECK_MAP_VALUE  = 3'd5,
    REG_GRID_COLS        = 3'd6,
    REG_GRID_ROWS        = 3'd7
  } cfg_reg_e;

  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int ADDR_SUM_W = 16;

  localparam logic [7:0] CELL_ONE = 8'd1;

  typedef struct packed {
    logic [4:0] mask_cols;
    logic [4:0] mask_rows;
    logic [3:0] center_col;
    logic [3:0] center_row;
    logic [7:0] check_mask_value;
    logic [7:0] check_map_value;
    logic [6:0] grid_cols;
    logic [6:0] grid_rows;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic load_mask;
    logic setup;
    logic walk;
    logic clr;
    logic capture;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic last_cell;
    logic clr_last;
  } status_t;

endpackage

// ===== sv/gmsc_cfg_regs.sv =====
module gmsc_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [gmsc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gmsc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output gmsc_pkg::cfg_t                      cfg
);
  import gmsc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mask_cols        <= 5'd1;
      cfg.mask_rows        <= 5'd1;
      cfg.center_col       <= 4'd0;
      cfg.center_row       <= 4'd0;
      cfg.check_mask_value <= 8'd0;
      cfg.check_map_value  <= 8'd1;
      cfg.grid_cols        <= 7'd64;
      cfg.grid_rows        <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_MASK_COLS:        cfg.mask_cols        <= cfg_data[4:0];
        REG_MASK_ROWS:        cfg.mask_rows        <= cfg_data[4:0];
        REG_CENTER_COL:       cfg.center_col       <= cfg_data[3:0];
        REG_CENTER_ROW:       cfg.center_row       <= cfg_data[3:0];
        REG_CHECK_MASK_VALUE: cfg.check_mask_value <= cfg_data[7:0];
        REG_CHECK_MAP_VALUE:  cfg.check_map_value  <= cfg_data[7:0];
        REG_GRID_COLS:        cfg.grid_cols        <= cfg_data[6:0];
        REG_GRID_ROWS:        cfg.grid_rows        <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/gmsc_ctrl.sv =====
module gmsc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           opcode,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  gmsc_pkg::status_t    status,
  output gmsc_pkg::cmd_t       cmd
);
  import gmsc_pkg::*;

  typedef enum logic [7:0] {
    S_INIT  = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_LOAD  = 8'b0000_0100,
    S_SETUP = 8'b0000_1000,
    S_WALK  = 8'b0001_0000,
    S_DRAIN = 8'b0010_0000,
    S_CLEAR = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_INIT: begin
        cmd.clr = 1'b1;
        if (status.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (opcode_e'(opcode))
            OP_LOAD:  state_next = S_LOAD;
            OP_CHECK: state_next = S_SETUP;
            OP_STAMP: state_next = S_SETUP;
            OP_CLEAR: state_next = S_CLEAR;
            default:  state_next = S_CLEAR;
          endcase
        end
      end
      S_LOAD: begin
        cmd.load_mask = 1'b1;
        state_next = S_DONE;
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_next = status.empty ? S_DONE : S_WALK;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (status.last_cell) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_DONE;
      end
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (status.clr_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.capture = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.capture) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_capture_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> (!out_valid || out_ready))
    else $error("result captured while the output register is still full");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again before the item finished");

endmodule

// ===== sv/gmsc_datapath.sv =====
module gmsc_datapath #(
  parameter int GRID_MAX_COLS = 64,
  parameter int GRID_MAX_ROWS = 64,
  parameter int MASK_MAX_DIM  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  gmsc_pkg::cfg_t       cfg,
  input  gmsc_pkg::cmd_t       cmd,
  output gmsc_pkg::status_t    status,
  input  logic [1:0]           opcode,
  input  logic [5:0]           cell_col,
  input  logic [5:0]           cell_row,
  input  logic [7:0]           mask_index,
  input  logic [7:0]           mask_value,
  output logic                 placement_ok
);
  import gmsc_pkg::*;

  localparam int GRID_DEPTH = GRID_MAX_COLS * GRID_MAX_ROWS;
  localparam int GA         = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;
  localparam int MASK_DEPTH = MASK_MAX_DIM * MASK_MAX_DIM;
  localparam int MA         = (MASK_DEPTH > 1) ? $clog2(MASK_DEPTH) : 1;

  logic [1:0]  op_q;
  logic [5:0]  col_q;
  logic [5:0]  row_q;
  logic [7:0]  idx_q;
  logic [7:0]  val_q;

  logic [7:0]  mask_mem [MASK_DEPTH];
  logic [7:0]  grid_mem [GRID_DEPTH];
  logic [7:0]  mask_rd;
  logic [7:0]  grid_rd;

  logic [5:0]  mc;
  logic [5:0]  mr;
  logic [6:0]  gc;
  logic [6:0]  gr;
  logic [5:0]  mc_m1;
  logic [5:0]  mr_m1;

  logic [5:0]  cc;
  logic [5:0]  rc;
  logic [MA-1:0] mi;
  logic [ADDR_SUM_W-1:0] row_base;
  logic [GA-1:0] clr_cnt;

  logic signed [7:0] x0;
  logic signed [7:0] y0;
  logic signed [7:0] gx;
  logic signed [7:0] gy;
  logic [6:0]  y0_pos;
  logic [13:0] base_prod;
  logic [ADDR_SUM_W-1:0] gsum;
  logic [GA-1:0] gi;
  logic        in_grid;
  logic        row_end;

  logic          p_valid;
  logic [GA-1:0] p_addr;
  logic          fail;

  logic          gwe;
  logic [GA-1:0] gwa;
  logic [7:0]    gwd;
  logic          idx_ok;

  assign mc = (32'(cfg.mask_cols) > MASK_MAX_DIM) ? 6'(MASK_MAX_DIM) : {1'b0, cfg.mask_cols};
  assign mr = (32'(cfg.mask_rows) > MASK_MAX_DIM) ? 6'(MASK_MAX_DIM) : {1'b0, cfg.mask_rows};
  assign gc = (32'(cfg.grid_cols) > GRID_MAX_COLS) ? 7'(GRID_MAX_COLS) : cfg.grid_cols;
  assign gr = (32'(cfg.grid_rows) > GRID_MAX_ROWS) ? 7'(GRID_MAX_ROWS) : cfg.grid_rows;
  assign mc_m1 = mc - 6'd1;
  assign mr_m1 = mr - 6'd1;

  assign x0 = $signed({2'b00, col_q}) - $signed({4'b0000, cfg.center_col});
  assign y0 = $signed({2'b00, row_q}) - $signed({4'b0000, cfg.center_row});
  assign gx = x0 + $signed({2'b00, cc});
  assign gy = y0 + $signed({2'b00, rc});
  assign y0_pos = y0[7] ? 7'd0 : y0[6:0];
  assign base_prod = {7'd0, y0_pos} * {7'd0, gc};

  assign in_grid = !gx[7] && (gx[6:0] < gc) && !gy[7] && (gy[6:0] < gr);
  assign gsum = row_base + {{(ADDR_SUM_W-8){1'b0}}, gx};
  assign gi = gsum[GA-1:0];
  assign row_end = (cc == mc_m1);

  assign status.empty     = (mc == 6'd0) || (mr == 6'd0);
  assign status.last_cell = row_end && (rc == mr_m1);
  assign status.clr_last  = (32'(clr_cnt) == GRID_DEPTH - 1);

  assign idx_ok = (32'(idx_q) < MASK_DEPTH);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q  <= opcode;
      col_q <= cell_col;
      row_q <= cell_row;
      idx_q <= mask_index;
      val_q <= mask_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_mask && idx_ok) begin
      mask_mem[MA'(idx_q)] <= val_q;
    end
    mask_rd <= mask_mem[mi];
  end

  always_comb begin
    if (cmd.clr) begin
      gwe = 1'b1;
      gwa = clr_cnt;
      gwd = CELL_ONE;
    end else begin
      gwe = p_valid && (op_q == OP_STAMP) && (mask_rd != CELL_ONE);
      gwa = p_addr;
      gwd = mask_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (gwe) begin
      grid_mem[gwa] <= gwd;
    end
    grid_rd <= grid_mem[gi];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      p_valid <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_cnt <= status.clr_last ? '0 : clr_cnt + 1'b1;
      end
      p_valid <= cmd.walk && in_grid;
    end
  end

  always_ff @(posedge clk) begin
    p_addr <= gi;
    if (cmd.setup) begin
      cc       <= '0;
      rc       <= '0;
      mi       <= '0;
      row_base <= {{(ADDR_SUM_W-14){1'b0}}, base_prod};
    end else if (cmd.walk) begin
      mi <= mi + 1'b1;
      if (row_end) begin
        cc <= '0;
        rc <= rc + 6'd1;
        if (!gy[7]) begin
          row_base <= row_base + {{(ADDR_SUM_W-7){1'b0}}, gc};
        end
      end else begin
        cc <= cc + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      fail <= 1'b0;
    end else if (p_valid && (op_q == OP_CHECK) && (mask_rd == cfg.check_mask_value)
                 && (grid_rd != cfg.check_map_value)) begin
      fail <= 1'b1;
    end
    if (cmd.capture) begin
      placement_ok <= (op_q == OP_CHECK) && !fail;
    end
  end

  a_pipe_follows_walk: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> $past(cmd.walk))
    else $error("grid pipeline stage valid without a walk step before it");

  a_write_only_clear_or_stamp: assert property (@(posedge clk) disable iff (rst)
    (gwe && !cmd.clr) |-> (op_q == OP_STAMP))
    else $error("grid written outside a clear pass or a stamp");

endmodule

// ===== sv/grid_mask_stamp_and_check_top.sv =====
// Grid mask stamp and check block.
// Input channel (in_valid/in_ready) carries one item per transfer: opcode,
// cell_col, cell_row, mask_index and mask_value. Output channel
// (out_valid/out_ready) returns one result per item: placement_ok and
// done_res, which is always 1.
// Configuration registers are written through cfg_we, cfg_index and
// cfg_data; the user must write them only while the block is idle, as
// the block itself does not enforce it. Each write is registered.
// A load item writes the mask memory and then moves its result into the
// output register. A check or stamp first sets up the row address
// product, then walks one mask cell per cycle, for the saturated mask
// size, through the mask and grid memory ports, then drains the grid
// pipeline. A clear item sweeps the grid memory one cell per cycle.
// After reset the same sweep runs over every grid cell with in_ready
// low; configuration writes are taken during it.
// One item is processed at a time. The result sits in an output register,
// so the next item is taken while it waits; if the receiver stalls, the
// following item waits after its work until the register is free.
module grid_mask_stamp_and_check_top #(
  parameter int GRID_MAX_COLS = 64,
  parameter int GRID_MAX_ROWS = 64,
  parameter int MASK_MAX_DIM  = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       opcode,
  input  logic [5:0]                       cell_col,
  input  logic [5:0]                       cell_row,
  input  logic [7:0]                       mask_index,
  input  logic [7:0]                       mask_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             placement_ok,
  output logic                             done_res,
  input  logic                             cfg_we,
  input  logic [gmsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gmsc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import gmsc_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  assign done_res = 1'b1;

  gmsc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gmsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  gmsc_datapath #(
    .GRID_MAX_COLS (GRID_MAX_COLS),
    .GRID_MAX_ROWS (GRID_MAX_ROWS),
    .MASK_MAX_DIM  (MASK_MAX_DIM)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .status       (status),
    .opcode       (opcode),
    .cell_col     (cell_col),
    .cell_row     (cell_row),
    .mask_index   (mask_index),
    .mask_value   (mask_value),
    .placement_ok (placement_ok)
  );

endmodule
